// ===== rtl/unicode_escape_decoder_defines.svh =====
// Assertion macros for the escape decoder.
`ifndef UNICODE_ESCAPE_DECODER_DEFINES_SVH
`define UNICODE_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ued_pkg.sv =====
`timescale 1ns / 1ps
package ued_pkg;

	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_U      = 8'h75;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_BSL  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  digit_count;
		logic [11:0] partial_value;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic        bad_escape;
		logic        end_of_run;
	} result_t;

	// Results of one item, ready to be pushed into the output queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} push_t;

	// Returns {is_hex, nibble}.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== rtl/unicode_escape_decoder.sv =====
`timescale 1ns / 1ps
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------------
// in       | in_valid  | in_stall  | char_in, last_byte
// out      | out_valid | out_stall | code_point, bad_escape, end_of_run
//
// A byte is taken into an input register and decoded against the escape state
// while it sits there; its zero, one or two results enter a 4-entry result queue
// when the queue has room, and the first of them then shows on out.
// One byte per cycle is taken while the queue holds at most two results; results
// drain one per cycle while out_stall is low.
// Reset clears the escape state, input valid and queue; out_stall backs up into in_stall.
`include "unicode_escape_decoder_defines.svh"
module unicode_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_point,
	output logic        bad_escape,
	output logic        end_of_run
);
	import ued_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	dec_state_t       state_q;
	dec_state_t       state_nxt;
	push_t            push;
	logic             has_room;
	logic [CNT_W-1:0] level;
	logic             advance;
	logic             load_s1;
	result_t          head;

	assign advance  = valid_s1 && has_room;
	assign load_s1  = !valid_s1 || has_room;
	assign in_stall = valid_s1 && !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{phase: PH_TEXT, digit_count: 2'd0, partial_value: 12'd0};
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last_byte;
		end
	end

	ued_decode u_decode (
		.state     (state_q),
		.char_val  (char_s1),
		.last_val  (last_s1),
		.state_nxt (state_nxt),
		.push      (push)
	);

	ued_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (push),
		.has_room  (has_room),
		.level     (level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign code_point = head.code_point;
	assign bad_escape = head.bad_escape;
	assign end_of_run = head.end_of_run;

	`UED_ASSERT_NOW(a_level_bound, 1'b1, level <= CNT_W'(QUEUE_DEPTH), "result queue overflow")
	`UED_ASSERT_NOW(a_bad_zero, out_valid && bad_escape, code_point == 16'd0, "error with code")
	`UED_ASSERT_NEXT(a_last_flush, advance && last_s1, state_q.phase == PH_TEXT, "no flush")
	`UED_ASSERT_NEXT(a_push_seen, advance && (push.count != 2'd0), out_valid, "result lost")

endmodule

// ===== rtl/ued_decode.sv =====
`timescale 1ns / 1ps
module ued_decode (
	input  ued_pkg::dec_state_t state,
	input  logic [7:0]          char_val,
	input  logic                last_val,
	output ued_pkg::dec_state_t state_nxt,
	output ued_pkg::push_t      push
);
	import ued_pkg::*;

	logic [4:0] hex;
	logic [1:0] cnt;
	result_t    r0;
	result_t    r1;
	result_t    lit_bs;
	result_t    lit_c;
	result_t    err;
	result_t    done;

	assign hex    = hex_value(char_val);
	assign lit_bs = '{code_point: {8'd0, CHAR_BSLASH}, bad_escape: 1'b0, end_of_run: 1'b0};
	assign lit_c  = '{code_point: {8'd0, char_val}, bad_escape: 1'b0, end_of_run: 1'b0};
	assign err    = '{code_point: 16'd0, bad_escape: 1'b1, end_of_run: 1'b0};
	assign done   = '{code_point: {state.partial_value, hex[3:0]}, bad_escape: 1'b0,
		end_of_run: 1'b0};

	always_comb begin
		state_nxt = state;
		cnt = 2'd0;
		r0  = '0;
		r1  = '0;
		case (state.phase)
			PH_BSL: begin
				if (char_val == CHAR_U) begin
					state_nxt.phase         = PH_HEX;
					state_nxt.digit_count   = 2'd0;
					state_nxt.partial_value = 12'd0;
				end else begin
					r0  = lit_bs;
					r1  = lit_c;
					cnt = 2'd2;
					state_nxt.phase = PH_TEXT;
				end
			end
			PH_HEX: begin
				if (hex[4]) begin
					if (state.digit_count != 2'd3) begin
						state_nxt.partial_value = {state.partial_value[7:0], hex[3:0]};
						state_nxt.digit_count   = state.digit_count + 2'd1;
					end else begin
						r0  = done;
						cnt = 2'd1;
						state_nxt.phase         = PH_TEXT;
						state_nxt.digit_count   = 2'd0;
						state_nxt.partial_value = 12'd0;
					end
				end else begin
					// Cut-short escape: error, then handle the byte as text.
					r0  = err;
					cnt = 2'd1;
					state_nxt.digit_count   = 2'd0;
					state_nxt.partial_value = 12'd0;
					if (char_val == CHAR_BSLASH) begin
						state_nxt.phase = PH_BSL;
					end else begin
						state_nxt.phase = PH_TEXT;
						r1  = lit_c;
						cnt = 2'd2;
					end
				end
			end
			default: begin
				if (char_val == CHAR_BSLASH) begin
					state_nxt.phase = PH_BSL;
				end else begin
					state_nxt.phase = PH_TEXT;
					r0  = lit_c;
					cnt = 2'd1;
				end
			end
		endcase

		// Flush pending state at the end of a message.
		if (last_val) begin
			if (state_nxt.phase == PH_BSL) begin
				if (cnt == 2'd0) begin
					r0 = lit_bs;
				end else begin
					r1 = lit_bs;
				end
				cnt = cnt + 2'd1;
			end else if (state_nxt.phase == PH_HEX) begin
				if (cnt == 2'd0) begin
					r0 = err;
				end else begin
					r1 = err;
				end
				cnt = cnt + 2'd1;
			end
			state_nxt.phase         = PH_TEXT;
			state_nxt.digit_count   = 2'd0;
			state_nxt.partial_value = 12'd0;
		end

		if (cnt == 2'd1) begin
			r0.end_of_run = 1'b1;
		end else if (cnt == 2'd2) begin
			r1.end_of_run = 1'b1;
		end
	end

	assign push.count = cnt;
	assign push.res0  = r0;
	assign push.res1  = r1;

endmodule

// ===== rtl/ued_out_queue.sv =====
`timescale 1ns / 1ps
module ued_out_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_en,
	input  ued_pkg::push_t                push,
	output logic                          has_room,
	output logic [ued_pkg::CNT_W-1:0]     level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ued_pkg::result_t              head
);
	import ued_pkg::*;

	localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(QUEUE_DEPTH - 2);

	result_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       n_push;
	logic             pop;

	assign n_push    = push_en ? push.count : 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign has_room  = (count_q <= ROOM_MAX);
	assign level     = count_q;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.res1;
		end
	end

endmodule

// ===== verif/ued_result_checker.sv =====
`timescale 1ns / 1ps
module ued_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] code_point,
	input  logic        bad_escape,
	input  logic        end_of_run,
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          decoded,
	output int          cut_short
);
	import ued_pkg::*;

	phase_t      esc_phase;
	logic [1:0]  digits_seen;
	logic [11:0] digits_value;
	result_t     expected_results[$];
	result_t     byte_results[$];

	int mismatch_count = 0;
	int checked_count  = 0;
	int decoded_count  = 0;
	int cut_count      = 0;
	int expected_left  = 0;

	assign mismatches = mismatch_count;
	assign pending    = expected_left;
	assign checked    = checked_count;
	assign decoded    = decoded_count;
	assign cut_short  = cut_count;

	task report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return int'(c) - 'h30;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return int'(c) - 'h57;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return int'(c) - 'h37;
		end
		return -1;
	endfunction

	task queue_result(input logic [15:0] cp, input logic bad);
		result_t r;
		r.code_point = cp;
		r.bad_escape = bad;
		r.end_of_run = 1'b0;
		byte_results.push_back(r);
		if (bad) begin
			cut_count++;
		end
	endtask

	task take_as_text(input logic [7:0] c);
		if (c == CHAR_BSLASH) begin
			esc_phase = PH_BSL;
		end else begin
			esc_phase = PH_TEXT;
			queue_result({8'h00, c}, 1'b0);
		end
	endtask

	task decode_byte(input logic [7:0] c, input logic last);
		int      nib;
		result_t tail;
		byte_results.delete();
		case (esc_phase)
			PH_BSL: begin
				if (c == CHAR_U) begin
					esc_phase    = PH_HEX;
					digits_seen  = 2'd0;
					digits_value = 12'h000;
				end else begin
					queue_result({8'h00, CHAR_BSLASH}, 1'b0);
					queue_result({8'h00, c}, 1'b0);
					esc_phase = PH_TEXT;
				end
			end
			PH_HEX: begin
				nib = nibble_of(c);
				if (nib < 0) begin
					// cut short: flag it, then treat the byte as text
					queue_result(16'h0000, 1'b1);
					digits_seen  = 2'd0;
					digits_value = 12'h000;
					take_as_text(c);
				end else if (digits_seen != 2'd3) begin
					digits_value = {digits_value[7:0], nib[3:0]};
					digits_seen  = digits_seen + 2'd1;
				end else begin
					queue_result({digits_value, nib[3:0]}, 1'b0);
					decoded_count++;
					esc_phase    = PH_TEXT;
					digits_seen  = 2'd0;
					digits_value = 12'h000;
				end
			end
			default: take_as_text(c);
		endcase
		if (last) begin
			if (esc_phase == PH_BSL) begin
				queue_result({8'h00, CHAR_BSLASH}, 1'b0);
			end else if (esc_phase == PH_HEX) begin
				queue_result(16'h0000, 1'b1);
			end
			esc_phase    = PH_TEXT;
			digits_seen  = 2'd0;
			digits_value = 12'h000;
		end
		if (byte_results.size() > 0) begin
			tail = byte_results.pop_back();
			tail.end_of_run = 1'b1;
			byte_results.push_back(tail);
		end
		foreach (byte_results[i]) begin
			expected_results.push_back(byte_results[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		result_t want;
		if (!arst_n) begin
			esc_phase    = PH_TEXT;
			digits_seen  = 2'd0;
			digits_value = 12'h000;
			expected_results.delete();
			expected_left <= 0;
		end else begin
			// check the outgoing item before predicting from the incoming one
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result code_point=%h bad=%b end=%b",
						code_point, bad_escape, end_of_run));
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (code_point !== want.code_point) begin
						report_mismatch($sformatf("code_point %h, expected %h",
							code_point, want.code_point));
					end
					if (bad_escape !== want.bad_escape) begin
						report_mismatch($sformatf("bad_escape %b, expected %b",
							bad_escape, want.bad_escape));
					end
					if (end_of_run !== want.end_of_run) begin
						report_mismatch($sformatf("end_of_run %b, expected %b (code_point %h)",
							end_of_run, want.end_of_run, want.code_point));
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(char_in, last_byte);
			end
			expected_left <= expected_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import ued_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int HOLD_CYCLES     = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in   = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] code_point;
	logic        bad_escape;
	logic        end_of_run;

	int mismatches;
	int pending;
	int checked;
	int decoded;
	int cut_short;

	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;
	int          bytes_sent   = 0;
	bit          hold_request = 1'b0;
	int          hold_left    = 0;
	int unsigned cycle_count  = 0;

	always #5 clk = ~clk;

	unicode_escape_decoder dut (.*);

	ued_result_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
		$display("** unicode_escape_decoder: FAILED **");
		$finish;
	end

	// result side: long hold on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) begin
			return 8'(8'h30 + v);
		end
		if ($urandom_range(1) == 1) begin
			return 8'(8'h61 + v - 10);
		end
		return 8'(8'h41 + v - 10);
	endfunction

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
			|| (c >= 8'h41 && c <= 8'h46);
	endfunction

	task automatic send_item(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_in   <= c;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_string(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], last_at_end && (i == s.len() - 1));
		end
	endtask

	initial begin
		logic [7:0] seq[$];
		logic [7:0] c;
		int         kind;
		int         n_hex;
		int         target;
		bit         force_last;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 35;
					rx_idle_pct = 74;
				end
				1: begin
					tx_idle_pct = 74;
					rx_idle_pct = 35;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// hold the result side so the queue fills and backs up into the input
			if (ph != 1) begin
				hold_request = 1'b1;
			end

			if (ph == 0) begin
				send_string("A", 1'b0);
				send_item(8'h00, 1'b0);
				send_item(8'hFF, 1'b0);
				send_string("\\n", 1'b0);
				send_string("\\\\", 1'b0);
				send_string("\\u09aF", 1'b1);
				send_string("\\ufAx", 1'b0);
				send_string("\\u1\\z", 1'b0);
				send_string("\\", 1'b1);
				send_string("\\u", 1'b1);
				send_string("B", 1'b1);
			end

			target = bytes_sent + ITEMS_PER_PHASE;
			while (bytes_sent < target) begin
				seq.delete();
				force_last = 1'b0;
				kind = $urandom_range(99);
				if (kind < 45) begin
					seq.push_back(8'($urandom_range(255)));
				end else if (kind < 70) begin
					seq.push_back(CHAR_BSLASH);
					seq.push_back(CHAR_U);
					repeat (4) seq.push_back(rand_hex_char());
				end else if (kind < 82) begin
					do c = 8'($urandom_range(255)); while (c == CHAR_U);
					seq.push_back(CHAR_BSLASH);
					seq.push_back(c);
				end else begin
					seq.push_back(CHAR_BSLASH);
					seq.push_back(CHAR_U);
					n_hex = $urandom_range(3);
					repeat (n_hex) seq.push_back(rand_hex_char());
					if (kind < 95) begin
						do c = 8'($urandom_range(255)); while (is_hex_char(c));
						seq.push_back(c);
					end else begin
						force_last = 1'b1;
					end
				end
				foreach (seq[i]) begin
					send_item(seq[i],
						(force_last && i == seq.size() - 1) || ($urandom_range(15) == 0));
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);

		$display("Sent %0d bytes under three stall mixes, with long output holds.", bytes_sent);
		$display("Checked %0d results: %0d decoded escapes, %0d cut-short escapes.",
			checked, decoded, cut_short);
		if (mismatches == 0) begin
			$display("** unicode_escape_decoder: PASSED **");
		end else begin
			$display("** unicode_escape_decoder: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ued_pkg.sv
rtl/ued_decode.sv
rtl/ued_out_queue.sv
rtl/unicode_escape_decoder.sv
verif/ued_result_checker.sv
verif/testbench.sv
